/* hw/rtl/gnss_binary_frame_parser_defines.svh */
// Assertion macros for the frame parser checker.
// Expects clk and rst_n in scope at the point of use.
`ifndef GNSS_BINARY_FRAME_PARSER_DEFINES_SVH
`define GNSS_BINARY_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define GBFP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbfp assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define GBFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbfp assertion failed");

`endif

/* hw/rtl/gbfp_pkg.sv */
// Package for the binary frame parser: framing constants, status codes
// and the parser phase type. No dependencies.
package gbfp_pkg;

    localparam int unsigned ADDR_W = 3;
    localparam logic REG_MAX_LEN = 1'b0;
    localparam logic [15:0] MAX_LEN_RESET = 16'd512;

    localparam logic [7:0] SYNC_FIRST = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;
    localparam logic [7:0] PVT_CLASS = 8'd1;
    localparam logic [7:0] PVT_ID = 8'd7;
    localparam logic [15:0] PVT_LEN = 16'd92;
    localparam logic [15:0] OFS_FIX = 16'd20;
    localparam logic [15:0] OFS_LON = 16'd24;
    localparam logic [15:0] OFS_LAT = 16'd28;
    localparam logic [15:0] LANE_COUNT = 16'd4;

    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_OK = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    typedef enum logic [8:0] {
        PH_SYNC1   = 9'b000000001,
        PH_SYNC2   = 9'b000000010,
        PH_CLASS   = 9'b000000100,
        PH_ID      = 9'b000001000,
        PH_LEN_LO  = 9'b000010000,
        PH_LEN_HI  = 9'b000100000,
        PH_PAYLOAD = 9'b001000000,
        PH_SUM_A   = 9'b010000000,
        PH_SUM_B   = 9'b100000000
    } phase_t;

endpackage

/* hw/rtl/gnss_binary_frame_parser.sv */
// Byte-serial deframer with Fletcher-8 check and NAV-PVT field capture.
// Each accepted byte yields a registered result beat in the cycle after it.
// Throughput: one byte per cycle while in_stall is low; the result register is the only stage.
// A held result stalls input only while the output side stalls.
// Reset (rst_n low, asynchronous): sync hunting, sums and captures zero,
// payload length limit 512, no result pending.
module gnss_binary_frame_parser
    import gbfp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          data_byte,
    input  logic                abandon,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [7:0]          frame_class,
    output logic [7:0]          msg_id,
    output logic [15:0]         frame_len,
    output logic [7:0]          payload_byte,
    output logic [15:0]         payload_index,
    output logic                payload_strobe,
    output logic                pvt_valid,
    output logic [7:0]          fix_type,
    output logic signed [31:0]  lat_e7,
    output logic signed [31:0]  lon_e7
);

    logic [15:0] max_len_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  id_reg, id_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] position_reg, position_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  rx_sum_a_reg, rx_sum_a_next;
    logic [7:0]  fix_reg, fix_next;
    logic [31:0] lat_reg, lat_next;
    logic [31:0] lon_reg, lon_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  status_reg, status_next;
    logic [7:0]  frame_class_reg, frame_class_next;
    logic [7:0]  msg_id_reg, msg_id_next;
    logic [15:0] frame_len_reg, frame_len_next;
    logic [7:0]  payload_byte_reg, payload_byte_next;
    logic [15:0] payload_index_reg, payload_index_next;
    logic        payload_strobe_reg, payload_strobe_next;
    logic        pvt_valid_reg, pvt_valid_next;
    logic [7:0]  fix_type_reg, fix_type_next;
    logic [31:0] lat_e7_reg, lat_e7_next;
    logic [31:0] lon_e7_reg, lon_e7_next;

    logic        accept;
    logic [7:0]  sum_a_add;
    logic [7:0]  sum_b_add;
    logic [15:0] len_full;
    logic [15:0] position_inc;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_MAX_LEN) ? {16'd0, max_len_reg} : 32'd0;
    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    assign sum_a_add    = sum_a_reg + data_byte;
    assign sum_b_add    = sum_b_reg + sum_a_add;
    assign len_full     = {data_byte, length_reg[7:0]};
    assign position_inc = position_reg + 16'd1;

    always_comb
    begin
        phase_next          = phase_reg;
        class_next          = class_reg;
        id_next             = id_reg;
        length_next         = length_reg;
        position_next       = position_reg;
        sum_a_next          = sum_a_reg;
        sum_b_next          = sum_b_reg;
        rx_sum_a_next       = rx_sum_a_reg;
        fix_next            = fix_reg;
        lat_next            = lat_reg;
        lon_next            = lon_reg;
        status_next         = ST_NONE;
        frame_class_next    = 8'd0;
        msg_id_next         = 8'd0;
        frame_len_next      = 16'd0;
        payload_byte_next   = 8'd0;
        payload_index_next  = 16'd0;
        payload_strobe_next = 1'b0;
        pvt_valid_next      = 1'b0;
        fix_type_next       = 8'd0;
        lat_e7_next         = 32'd0;
        lon_e7_next         = 32'd0;

        if (abandon)
        begin
            phase_next    = PH_SYNC1;
            class_next    = 8'd0;
            id_next       = 8'd0;
            length_next   = 16'd0;
            position_next = 16'd0;
            sum_a_next    = 8'd0;
            sum_b_next    = 8'd0;
            rx_sum_a_next = 8'd0;
        end
        else
        begin
            unique case (phase_reg)
                PH_SYNC1:
                begin
                    if (data_byte == SYNC_FIRST)
                        phase_next = PH_SYNC2;
                end
                PH_SYNC2:
                begin
                    if (data_byte == SYNC_SECOND)
                    begin
                        phase_next = PH_CLASS;
                        sum_a_next = 8'd0;
                        sum_b_next = 8'd0;
                    end
                    else if (data_byte == SYNC_FIRST)
                        phase_next = PH_SYNC2;
                    else
                        phase_next = PH_SYNC1;
                end
                PH_CLASS:
                begin
                    class_next = data_byte;
                    sum_a_next = sum_a_add;
                    sum_b_next = sum_b_add;
                    phase_next = PH_ID;
                end
                PH_ID:
                begin
                    id_next    = data_byte;
                    sum_a_next = sum_a_add;
                    sum_b_next = sum_b_add;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    length_next = {8'd0, data_byte};
                    sum_a_next  = sum_a_add;
                    sum_b_next  = sum_b_add;
                    phase_next  = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    if (len_full > max_len_reg)
                    begin
                        // drop oversized frame silently
                        phase_next    = PH_SYNC1;
                        class_next    = 8'd0;
                        id_next       = 8'd0;
                        length_next   = 16'd0;
                        position_next = 16'd0;
                        sum_a_next    = 8'd0;
                        sum_b_next    = 8'd0;
                        rx_sum_a_next = 8'd0;
                    end
                    else
                    begin
                        length_next   = len_full;
                        sum_a_next    = sum_a_add;
                        sum_b_next    = sum_b_add;
                        position_next = 16'd0;
                        phase_next    = (len_full == 16'd0) ? PH_SUM_A : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    payload_byte_next   = data_byte;
                    payload_index_next  = position_reg;
                    payload_strobe_next = 1'b1;
                    sum_a_next          = sum_a_add;
                    sum_b_next          = sum_b_add;
                    if (position_reg == OFS_FIX)
                        fix_next = data_byte;
                    else if (position_reg >= OFS_LON && position_reg < OFS_LON + LANE_COUNT)
                        lon_next[{position_reg[1:0], 3'b000} +: 8] = data_byte;
                    else if (position_reg >= OFS_LAT && position_reg < OFS_LAT + LANE_COUNT)
                        lat_next[{position_reg[1:0], 3'b000} +: 8] = data_byte;
                    position_next = position_inc;
                    if (position_inc >= length_reg)
                        phase_next = PH_SUM_A;
                end
                PH_SUM_A:
                begin
                    rx_sum_a_next = data_byte;
                    phase_next    = PH_SUM_B;
                end
                PH_SUM_B:
                begin
                    if (rx_sum_a_reg == sum_a_reg && data_byte == sum_b_reg)
                    begin
                        status_next      = ST_OK;
                        frame_class_next = class_reg;
                        msg_id_next      = id_reg;
                        frame_len_next   = length_reg;
                        if (class_reg == PVT_CLASS && id_reg == PVT_ID
                            && length_reg == PVT_LEN)
                        begin
                            pvt_valid_next = 1'b1;
                            fix_type_next  = fix_reg;
                            lat_e7_next    = lat_reg;
                            lon_e7_next    = lon_reg;
                        end
                    end
                    else
                        status_next = ST_BAD;
                    phase_next    = PH_SYNC1;
                    class_next    = 8'd0;
                    id_next       = 8'd0;
                    length_next   = 16'd0;
                    position_next = 16'd0;
                    sum_a_next    = 8'd0;
                    sum_b_next    = 8'd0;
                    rx_sum_a_next = 8'd0;
                end
                default:
                begin
                    phase_next    = PH_SYNC1;
                    class_next    = 8'd0;
                    id_next       = 8'd0;
                    length_next   = 16'd0;
                    position_next = 16'd0;
                    sum_a_next    = 8'd0;
                    sum_b_next    = 8'd0;
                    rx_sum_a_next = 8'd0;
                end
            endcase
        end
    end

    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_LEN_RESET;
        else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_LEN)
            max_len_reg <= pwdata[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SYNC1;
            class_reg     <= 8'd0;
            id_reg        <= 8'd0;
            length_reg    <= 16'd0;
            position_reg  <= 16'd0;
            sum_a_reg     <= 8'd0;
            sum_b_reg     <= 8'd0;
            rx_sum_a_reg  <= 8'd0;
            fix_reg       <= 8'd0;
            lat_reg       <= 32'd0;
            lon_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg    <= phase_next;
                class_reg    <= class_next;
                id_reg       <= id_next;
                length_reg   <= length_next;
                position_reg <= position_next;
                sum_a_reg    <= sum_a_next;
                sum_b_reg    <= sum_b_next;
                rx_sum_a_reg <= rx_sum_a_next;
                fix_reg      <= fix_next;
                lat_reg      <= lat_next;
                lon_reg      <= lon_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg         <= status_next;
            frame_class_reg    <= frame_class_next;
            msg_id_reg         <= msg_id_next;
            frame_len_reg      <= frame_len_next;
            payload_byte_reg   <= payload_byte_next;
            payload_index_reg  <= payload_index_next;
            payload_strobe_reg <= payload_strobe_next;
            pvt_valid_reg      <= pvt_valid_next;
            fix_type_reg       <= fix_type_next;
            lat_e7_reg         <= lat_e7_next;
            lon_e7_reg         <= lon_e7_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign frame_class    = frame_class_reg;
    assign msg_id         = msg_id_reg;
    assign frame_len      = frame_len_reg;
    assign payload_byte   = payload_byte_reg;
    assign payload_index  = payload_index_reg;
    assign payload_strobe = payload_strobe_reg;
    assign pvt_valid      = pvt_valid_reg;
    assign fix_type       = fix_type_reg;
    assign lat_e7         = $signed(lat_e7_reg);
    assign lon_e7         = $signed(lon_e7_reg);

endmodule

/* hw/rtl/gbfp_checker.sv */
// Port-level checker for the frame parser, bound into the parser module.
// Depends on gbfp_pkg and gnss_binary_frame_parser_defines.svh.
`include "gnss_binary_frame_parser_defines.svh"

module gbfp_checker
    import gbfp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic        payload_strobe,
    input logic        pvt_valid,
    input logic [15:0] payload_index
);

    `GBFP_ASSERT_NEXT(a_beat_yields_result, in_valid && !in_stall, out_valid)
    `GBFP_ASSERT_IMPL(a_stall_follows_output, 1'b1, in_stall == (out_valid && out_stall))
    `GBFP_ASSERT_IMPL(a_pvt_only_when_ok, out_valid && pvt_valid, status == ST_OK)
    `GBFP_ASSERT_IMPL(a_strobe_no_status, out_valid && payload_strobe, status == ST_NONE)
    `GBFP_ASSERT_NEXT(a_held_result_stable, out_valid && out_stall,
        out_valid && $stable(status) && $stable(payload_index))

endmodule

bind gnss_binary_frame_parser gbfp_checker u_gbfp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .payload_strobe (payload_strobe),
    .pvt_valid      (pvt_valid),
    .payload_index  (payload_index)
);
